[rtl/ctcgd_pkg.sv]
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types, constants and exp tables for the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  // sizes
  localparam int MAX_CLASSES = 8192;
  localparam int CLASS_W     = $clog2(MAX_CLASSES);
  localparam int MAX_STEPS   = 1024;
  localparam int STEP_W      = $clog2(MAX_STEPS);
  localparam int KEY_W       = 14;
  localparam int LOGIT_W     = 16;
  localparam int CONF_W      = 16;
  localparam int SUM_W       = 32;
  localparam int EXP_W       = 17;

  // divider: 17 quotient bits, one per cycle
  localparam int DIV_STEPS   = 17;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [KEY_W-1:0]   KEY_COUNT_RESET = 14'd5531;
  localparam logic [SUM_W-1:0]   SUM_ONE         = 32'h0001_0000;
  localparam logic [CONF_W-1:0]  CONF_MAX        = 16'hFFFF;

  // register map (word index taken from paddr[2])
  localparam int PADDR_W = 3;
  localparam logic REG_KEY_COUNT = 1'b0;

  // request payloads
  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic                      row_end;
    logic                      sequence_start;
  } in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] key_index;
    logic [CONF_W-1:0]  confidence;
    logic [STEP_W-1:0]  time_step;
  } out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP1,
    ST_EXP2,
    ST_SCALE,
    ST_UPDATE,
    ST_CLOSE,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exp1;
    logic exp2;
    logic scale;
    logic update;
    logic close;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic emit;
    logic sum_small;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // round(65536*exp(-n)), zero past the table
  function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
    logic [EXP_W-1:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536*exp(-h/16))
  function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] h);
    logic [EXP_W-1:0] v;
    case (h)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // round(65536*exp(-l/256))
  function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] l);
    logic [EXP_W-1:0] v;
    case (l)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65280;
      4'd2:    v = 17'd65026;
      4'd3:    v = 17'd64772;
      4'd4:    v = 17'd64520;
      4'd5:    v = 17'd64268;
      4'd6:    v = 17'd64018;
      4'd7:    v = 17'd63768;
      4'd8:    v = 17'd63520;
      4'd9:    v = 17'd63272;
      4'd10:   v = 17'd63025;
      4'd11:   v = 17'd62780;
      4'd12:   v = 17'd62535;
      4'd13:   v = 17'd62291;
      4'd14:   v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

[rtl/ctc_greedy_decoder_core.sv]
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core
// CTC best-path decoder with online softmax confidence and APB key count.
// ----------------------------------------------------------------------------
// Class scores enter one per request; a score without row end passes
// through accept, two table-exp multiplies, the sum rescale multiply and
// the state update, all through one shared sequence. A row end adds a
// row close step; when a symbol is emitted, the radix-2 reciprocal divider
// runs and the output register is loaded (the divider is skipped when the
// sum is below one, which saturates). A pending result does not block new
// scores; only the next emitted result waits for the output register to
// free up.
module ctc_greedy_decoder_core (
  input  logic                              clk,
  input  logic                              rst,
  // scores
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ctcgd_pkg::in_t                    in_data,
  // symbols
  output logic                              out_valid,
  input  logic                              out_ready,
  output ctcgd_pkg::out_t                   out_data,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ctcgd_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [ctcgd_pkg::KEY_W-1:0] key_count;
  ctcgd_pkg::ctrl_cmd_t        cmd;
  ctcgd_pkg::dp_status_t       status;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == ctcgd_pkg::REG_KEY_COUNT;

  // key count register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= ctcgd_pkg::KEY_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      key_count <= pwdata[ctcgd_pkg::KEY_W-1:0];
    end
  end

  // register read
  assign prdata = reg_sel ? {{(32-ctcgd_pkg::KEY_W){1'b0}}, key_count} : 32'd0;

  ctcgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  ctcgd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .key_count (key_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/ctcgd_ctrl.sv]
// ----------------------------------------------------------------------------
// ctcgd_ctrl
// Sequencer: walks each score through the exp, rescale and update steps;
// at a row end it closes the row and, for an emitted symbol with sum not below one, runs the divider.
// ----------------------------------------------------------------------------
module ctcgd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output ctcgd_pkg::ctrl_cmd_t  cmd,
  input  ctcgd_pkg::dp_status_t status
);

  ctcgd_pkg::ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctcgd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ctcgd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ctcgd_pkg::ST_EXP1;
        end
      end
      ctcgd_pkg::ST_EXP1: begin
        cmd.exp1   = 1'b1;
        state_next = ctcgd_pkg::ST_EXP2;
      end
      ctcgd_pkg::ST_EXP2: begin
        cmd.exp2   = 1'b1;
        state_next = ctcgd_pkg::ST_SCALE;
      end
      ctcgd_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ctcgd_pkg::ST_UPDATE;
      end
      ctcgd_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.last ? ctcgd_pkg::ST_CLOSE : ctcgd_pkg::ST_IDLE;
      end
      ctcgd_pkg::ST_CLOSE: begin
        cmd.close = 1'b1;
        if (!status.emit) begin
          state_next = ctcgd_pkg::ST_IDLE;
        end else if (status.sum_small) begin
          state_next = ctcgd_pkg::ST_OUT;
        end else begin
          state_next = ctcgd_pkg::ST_DIV;
        end
      end
      ctcgd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ctcgd_pkg::ST_OUT;
        end
      end
      ctcgd_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ctcgd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ctcgd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ctcgd_datapath.sv]
// ----------------------------------------------------------------------------
// ctcgd_datapath
// Row state, table exp, online softmax sum, argmax, repeat filter,
// radix-2 reciprocal divider and the output register.
// ----------------------------------------------------------------------------
module ctcgd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ctcgd_pkg::ctrl_cmd_t             cmd,
  output ctcgd_pkg::dp_status_t            status,
  input  ctcgd_pkg::in_t                   in_data,
  input  logic [ctcgd_pkg::KEY_W-1:0]      key_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ctcgd_pkg::out_t                  out_data
);

  // captured request
  logic signed [ctcgd_pkg::LOGIT_W-1:0] score;
  logic                                 last;

  // row and sequence state
  logic signed [ctcgd_pkg::LOGIT_W-1:0] running_max;
  logic [ctcgd_pkg::CLASS_W-1:0]        max_class;
  logic [ctcgd_pkg::CLASS_W-1:0]        class_position;
  logic                                 row_full;
  logic [ctcgd_pkg::SUM_W-1:0]          exp_sum;
  logic [ctcgd_pkg::CLASS_W-1:0]        previous_class;
  logic [ctcgd_pkg::STEP_W-1:0]         row_count;

  // exp pipeline registers
  logic                                 gt;
  logic                                 far;
  logic [3:0]                           lo_idx;
  logic [ctcgd_pkg::EXP_W-1:0]          t_part;
  logic [ctcgd_pkg::EXP_W-1:0]          e_val;
  logic [ctcgd_pkg::SUM_W:0]            scaled;

  // divider and result holding
  logic [ctcgd_pkg::SUM_W-1:0]          rem;
  logic [ctcgd_pkg::EXP_W-1:0]          num_low;
  logic [ctcgd_pkg::EXP_W-1:0]          quo;
  logic [ctcgd_pkg::DIV_CNT_W-1:0]      div_cnt;
  logic                                 sum_below_one;
  logic [ctcgd_pkg::CLASS_W-1:0]        key_hold;
  logic [ctcgd_pkg::STEP_W-1:0]         step_hold;

  // combinational
  logic [ctcgd_pkg::LOGIT_W:0]          diff_up, diff_dn;
  logic                                 gt_now;
  logic [ctcgd_pkg::LOGIT_W-1:0]        score_gap;
  logic [2*ctcgd_pkg::EXP_W-1:0]        p1, p2;
  logic [ctcgd_pkg::SUM_W+ctcgd_pkg::EXP_W-1:0] p3;
  logic [ctcgd_pkg::SUM_W+1:0]          sum_gt;
  logic [ctcgd_pkg::SUM_W:0]            sum_add;
  logic [ctcgd_pkg::SUM_W-1:0]          sum_gt_sat, sum_add_sat;
  logic                                 emit;
  logic [ctcgd_pkg::SUM_W:0]            trial;
  logic                                 ge;
  logic [ctcgd_pkg::CONF_W-1:0]         conf;

  // distance to the running max and first exp product
  always_comb begin
    gt_now    = score > running_max;
    diff_up   = {score[ctcgd_pkg::LOGIT_W-1], score}
              - {running_max[ctcgd_pkg::LOGIT_W-1], running_max};
    diff_dn   = {running_max[ctcgd_pkg::LOGIT_W-1], running_max}
              - {score[ctcgd_pkg::LOGIT_W-1], score};
    score_gap = gt_now ? diff_up[ctcgd_pkg::LOGIT_W-1:0] : diff_dn[ctcgd_pkg::LOGIT_W-1:0];
    p1        = ctcgd_pkg::exp_int(score_gap[11:8]) * ctcgd_pkg::exp_hi(score_gap[7:4]);
  end

  // second exp product and rescale product
  assign p2 = t_part * ctcgd_pkg::exp_lo(lo_idx);
  assign p3 = exp_sum * e_val;

  // saturating sums
  always_comb begin
    sum_gt      = {1'b0, scaled} + {2'b00, ctcgd_pkg::SUM_ONE};
    sum_add     = {1'b0, exp_sum} + {{(ctcgd_pkg::SUM_W-ctcgd_pkg::EXP_W+1){1'b0}}, e_val};
    sum_gt_sat  = (sum_gt[ctcgd_pkg::SUM_W+1:ctcgd_pkg::SUM_W] != 2'b00)
                ? '1 : sum_gt[ctcgd_pkg::SUM_W-1:0];
    sum_add_sat = sum_add[ctcgd_pkg::SUM_W] ? '1 : sum_add[ctcgd_pkg::SUM_W-1:0];
  end

  // row close decision
  assign emit = (max_class != '0)
             && ({1'b0, max_class} < key_count)
             && (max_class != previous_class);

  // divider step
  always_comb begin
    trial = {rem, num_low[ctcgd_pkg::EXP_W-1]};
    ge    = trial >= {1'b0, exp_sum};
  end

  // saturated confidence
  assign conf = (sum_below_one || quo[ctcgd_pkg::EXP_W-1]) ? ctcgd_pkg::CONF_MAX
              : quo[ctcgd_pkg::CONF_W-1:0];

  // status
  always_comb begin
    status.last      = last;
    status.emit      = emit;
    status.sum_small = exp_sum[ctcgd_pkg::SUM_W-1:16] == '0;
    status.div_done  = div_cnt == ctcgd_pkg::DIV_CNT_W'(ctcgd_pkg::DIV_STEPS - 1);
    status.out_free  = !out_valid || out_ready;
  end

  // request capture and row / sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max    <= '0;
      max_class      <= '0;
      class_position <= '0;
      row_full       <= 1'b0;
      exp_sum        <= '0;
      previous_class <= '0;
      row_count      <= '0;
    end else begin
      if (cmd.accept && in_data.sequence_start) begin
        previous_class <= '0;
        row_count      <= '0;
        class_position <= '0;
        row_full       <= 1'b0;
      end
      if (cmd.update && !row_full) begin
        if (class_position == '0) begin
          running_max <= score;
          max_class   <= '0;
          exp_sum     <= ctcgd_pkg::SUM_ONE;
        end else if (gt) begin
          running_max <= score;
          max_class   <= class_position;
          exp_sum     <= sum_gt_sat;
        end else begin
          exp_sum     <= sum_add_sat;
        end
        if (class_position == ctcgd_pkg::CLASS_W'(ctcgd_pkg::MAX_CLASSES - 1)) begin
          row_full <= 1'b1;
        end else begin
          class_position <= class_position + 1'b1;
        end
      end
      if (cmd.close) begin
        previous_class <= max_class;
        if (row_count == ctcgd_pkg::STEP_W'(ctcgd_pkg::MAX_STEPS - 1)) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
        class_position <= '0;
        row_full       <= 1'b0;
      end
    end
  end

  // payload pipeline: capture, exp, rescale, divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      score <= in_data.logit;
      last  <= in_data.row_end;
    end
    if (cmd.exp1) begin
      gt     <= gt_now;
      far    <= score_gap[ctcgd_pkg::LOGIT_W-1:8] >= 8'd12;
      lo_idx <= score_gap[3:0];
      t_part <= ctcgd_pkg::EXP_W'((p1 + 34'd32768) >> 16);
    end
    if (cmd.exp2) begin
      e_val <= far ? '0 : ctcgd_pkg::EXP_W'((p2 + 34'd32768) >> 16);
    end
    if (cmd.scale) begin
      scaled <= (ctcgd_pkg::SUM_W + 1)'((p3 + 49'd32768) >> 16);
    end
    if (cmd.close) begin
      key_hold      <= max_class - 1'b1;
      step_hold     <= row_count;
      sum_below_one <= exp_sum[ctcgd_pkg::SUM_W-1:16] == '0;
      // dividend is 2^32 + exp_sum/2; its top 16 bits seed the remainder
      rem           <= {16'd0, 2'b10, exp_sum[ctcgd_pkg::SUM_W-1:18]};
      num_low       <= exp_sum[17:1];
      quo           <= '0;
      div_cnt       <= '0;
    end
    if (cmd.div_step) begin
      rem     <= ge ? ctcgd_pkg::SUM_W'(trial - {1'b0, exp_sum}) : trial[ctcgd_pkg::SUM_W-1:0];
      num_low <= {num_low[ctcgd_pkg::EXP_W-2:0], 1'b0};
      quo     <= {quo[ctcgd_pkg::EXP_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.out_load) begin
      out_data.key_index  <= key_hold;
      out_data.confidence <= conf;
      out_data.time_step  <= step_hold;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // remainder stays below the divisor while dividing
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> rem < exp_sum)
    else $error("divider remainder not below divisor");

  // the result register is only loaded when it is free
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending result");

  // a full row sits at the last class position
  assert property (@(posedge clk) disable iff (rst)
    row_full |-> class_position == ctcgd_pkg::CLASS_W'(ctcgd_pkg::MAX_CLASSES - 1))
    else $error("row full flag out of step with class position");

  // every processed score leaves the sum at or above one
  assert property (@(posedge clk) disable iff (rst)
    $past(cmd.update) && !$past(row_full) |-> exp_sum >= ctcgd_pkg::SUM_ONE)
    else $error("softmax sum dropped below one");

endmodule
